// ----- sv/scl_pkg.sv -----
`timescale 1ns / 1ps

package scl_pkg;

  localparam int unsigned MAX_LINE_LENGTH = 32;
  localparam int unsigned POS_W           = $clog2(MAX_LINE_LENGTH);
  localparam int unsigned NUM_KW          = 4;
  localparam int unsigned KW_MAX_LEN      = 5;
  localparam int unsigned KW_IDX_W        = $clog2(KW_MAX_LEN);
  localparam int unsigned KW_LEN_W        = 3;
  localparam int unsigned ARG_OFFSET_W    = 6;

  localparam logic [7:0] CHAR_NUL = 8'd0;
  localparam logic [7:0] CHAR_TAB = 8'd9;
  localparam logic [7:0] CHAR_LF  = 8'd10;
  localparam logic [7:0] CHAR_CR  = 8'd13;
  localparam logic [7:0] CHAR_SP  = 8'd32;

  typedef enum logic [2:0] {
    CMD_IDN     = 3'd0,
    CMD_ON      = 3'd1,
    CMD_OFF     = 3'd2,
    CMD_HELP    = 3'd3,
    CMD_UNKNOWN = 3'd4,
    CMD_EMPTY   = 3'd5
  } command_e;

  // keywords stored lower case, unused tail bytes are zero
  localparam logic [NUM_KW-1:0][KW_MAX_LEN-1:0][7:0] KW_TEXT = '{
    '{8'h00, 8'h70, 8'h6c, 8'h65, 8'h68},  // help
    '{8'h00, 8'h00, 8'h66, 8'h66, 8'h6f},  // off
    '{8'h00, 8'h00, 8'h00, 8'h6e, 8'h6f},  // on
    '{8'h3f, 8'h6e, 8'h64, 8'h69, 8'h2a}   // *idn?
  };

  localparam logic [NUM_KW-1:0][KW_LEN_W-1:0] KW_LEN = '{3'd4, 3'd3, 3'd2, 3'd5};

  typedef struct packed {
    logic                    echo_valid;
    logic [7:0]              echo_char;
    logic                    echo_newline;
    logic                    line_done;
    command_e                command_code;
    logic [ARG_OFFSET_W-1:0] arg_offset;
  } result_t;

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5a) begin
      r = c + 8'd32;
    end
    return r;
  endfunction

endpackage

// ----- sv/scl_rx_if.sv -----
`timescale 1ns / 1ps

interface scl_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_char;

  modport source (output valid, output rx_char, input ready);
  modport sink (input valid, input rx_char, output ready);
endinterface

// ----- sv/scl_cfg_if.sv -----
`timescale 1ns / 1ps

interface scl_cfg_if;
  logic valid;
  logic ready;
  logic echo_enable;

  modport source (output valid, output echo_enable, input ready);
  modport sink (input valid, input echo_enable, output ready);
endinterface

// ----- sv/scl_res_if.sv -----
`timescale 1ns / 1ps

interface scl_res_if;
  logic                              valid;
  logic                              ready;
  logic                              echo_valid;
  logic [7:0]                        echo_char;
  logic                              echo_newline;
  logic                              line_done;
  logic [2:0]                        command_code;
  logic [scl_pkg::ARG_OFFSET_W-1:0]  arg_offset;

  modport source (
    output valid, output echo_valid, output echo_char, output echo_newline,
    output line_done, output command_code, output arg_offset, input ready
  );
  modport sink (
    input valid, input echo_valid, input echo_char, input echo_newline,
    input line_done, input command_code, input arg_offset, output ready
  );
endinterface

// ----- sv/serial_command_line_matcher.sv -----
`timescale 1ns / 1ps
// a word accepted into the input register is decoded combinationally and registered into the
// output register that drives the result port, once that register is free or being read
// throughput: one word per cycle while results are taken, the line state updates once per word
// reset: echo enabled, line position zero, all keywords live, no word held
// the configuration port is always ready

module serial_command_line_matcher (
  input  logic         clk_i,
  input  logic         rst_ni,
  scl_rx_if.sink       rx_i,
  scl_cfg_if.sink      cfg_i,
  scl_res_if.source    res_o
);

  logic             echo_q;
  logic             in_valid_q;
  logic [7:0]       in_char_q;
  logic             out_valid_q;
  scl_pkg::result_t out_q;
  scl_pkg::result_t result;
  logic             advance;
  logic             step;
  logic             in_ready;

  assign advance  = !out_valid_q || res_o.ready;
  assign step     = in_valid_q && advance;
  assign in_ready = !in_valid_q || advance;

  assign rx_i.ready  = in_ready;
  assign cfg_i.ready = 1'b1;

  scl_matcher u_matcher (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .rx_char_i     (in_char_q),
    .echo_enable_i (echo_q),
    .result_o      (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      echo_q      <= 1'b1;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        echo_q <= cfg_i.echo_enable;
      end
      if (in_ready) begin
        in_valid_q <= rx_i.valid;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && rx_i.valid) begin
      in_char_q <= rx_i.rx_char;
    end
    if (step) begin
      out_q <= result;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.echo_valid   = out_q.echo_valid;
  assign res_o.echo_char    = out_q.echo_char;
  assign res_o.echo_newline = out_q.echo_newline;
  assign res_o.line_done    = out_q.line_done;
  assign res_o.command_code = out_q.command_code;
  assign res_o.arg_offset   = out_q.arg_offset;

endmodule

// ----- sv/scl_matcher.sv -----
`timescale 1ns / 1ps

module scl_matcher (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic [7:0]         rx_char_i,
  input  logic               echo_enable_i,
  output scl_pkg::result_t   result_o
);

  logic [scl_pkg::POS_W-1:0]  pos_q, pos_d;
  logic [scl_pkg::NUM_KW-1:0] alive_q, alive_d;
  logic [scl_pkg::POS_W-1:0]  cnt_q, cnt_d;
  logic [scl_pkg::NUM_KW-1:0] skip_q, skip_d;

  logic                       term;
  logic                       blank;
  logic                       inc;
  logic                       sk;
  logic [scl_pkg::POS_W:0]    pos_next;
  logic [scl_pkg::POS_W-1:0]  len_ext;
  logic [scl_pkg::POS_W:0]    offset_sum;
  logic [7:0]                 kw_char;
  scl_pkg::command_e          code;
  logic [scl_pkg::ARG_OFFSET_W-1:0] offset;

  always_comb begin
    term       = (rx_char_i == scl_pkg::CHAR_CR) || (rx_char_i == scl_pkg::CHAR_NUL);
    blank      = (rx_char_i == scl_pkg::CHAR_SP) || (rx_char_i == scl_pkg::CHAR_TAB);
    pos_d      = pos_q;
    alive_d    = alive_q;
    cnt_d      = cnt_q;
    skip_d     = skip_q;
    code       = scl_pkg::CMD_IDN;
    offset     = '0;
    inc        = 1'b0;
    sk         = 1'b0;
    len_ext    = '0;
    offset_sum = '0;
    kw_char    = '0;
    pos_next   = {1'b0, pos_q} + 1'b1;

    if (term) begin
      if (pos_q == '0) begin
        code = scl_pkg::CMD_EMPTY;
      end else begin
        code = scl_pkg::CMD_UNKNOWN;
        // lowest index wins
        for (int k = scl_pkg::NUM_KW - 1; k >= 0; k--) begin
          len_ext = scl_pkg::POS_W'(scl_pkg::KW_LEN[k]);
          if (alive_q[k] && pos_q >= len_ext) begin
            code       = scl_pkg::command_e'(3'(k));
            offset_sum = {1'b0, len_ext} + {1'b0, cnt_q};
            offset     = scl_pkg::ARG_OFFSET_W'(offset_sum);
          end
        end
      end
      pos_d   = '0;
      alive_d = '1;
      cnt_d   = '0;
      skip_d  = '0;
    end else if (rx_char_i != scl_pkg::CHAR_LF) begin
      for (int k = 0; k < scl_pkg::NUM_KW; k++) begin
        len_ext = scl_pkg::POS_W'(scl_pkg::KW_LEN[k]);
        if (alive_q[k]) begin
          if (pos_q < len_ext) begin
            kw_char = scl_pkg::KW_TEXT[k][pos_q[scl_pkg::KW_IDX_W-1:0]];
            if (scl_pkg::fold_case(rx_char_i) != kw_char) begin
              alive_d[k] = 1'b0;
            end
          end else begin
            sk        = skip_q[k] || (pos_q == len_ext);
            skip_d[k] = sk && blank;
            inc       = inc || (sk && blank);
          end
        end
      end
      // at most one keyword is still alive past its end, so one counter
      cnt_d = cnt_q + scl_pkg::POS_W'(inc);
      if (pos_next >= (scl_pkg::POS_W + 1)'(scl_pkg::MAX_LINE_LENGTH)) begin
        pos_d   = '0;
        alive_d = '1;
        cnt_d   = '0;
        skip_d  = '0;
      end else begin
        pos_d = pos_next[scl_pkg::POS_W-1:0];
      end
    end

    result_o.echo_valid   = echo_enable_i;
    result_o.echo_char    = rx_char_i;
    result_o.echo_newline = echo_enable_i && term;
    result_o.line_done    = term;
    result_o.command_code = code;
    result_o.arg_offset   = offset;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      alive_q <= '1;
      cnt_q   <= '0;
      skip_q  <= '0;
    end else if (step_i) begin
      pos_q   <= pos_d;
      alive_q <= alive_d;
      cnt_q   <= cnt_d;
      skip_q  <= skip_d;
    end
  end

endmodule
